### design/i2c_master_register_transfer_assert.svh
`ifndef I2C_MASTER_REGISTER_TRANSFER_ASSERT_SVH
`define I2C_MASTER_REGISTER_TRANSFER_ASSERT_SVH

// Checks sampled on aclk and held off while aresetn is low.
`define I2CMRT_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("i2cmrt assertion failed");

// Checks sampled on aclk that also hold during reset.
`define I2CMRT_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("i2cmrt check failed");

`endif

### design/i2cmrt_pkg.sv
package i2cmrt_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_DATA  = 2'd3;

    localparam logic [1:0] CFG_RESTART_WAIT = 2'd0;
    localparam logic [1:0] CFG_STOP_WAIT    = 2'd1;

    localparam logic [7:0] RESTART_WAIT_RESET = 8'd10;
    localparam logic [7:0] STOP_WAIT_RESET    = 8'd30;

    typedef struct packed {
        logic [1:0] op;
        logic       sda_in;
        logic [6:0] device_addr;
        logic [7:0] reg_addr;
        logic [7:0] byte_count;
        logic [7:0] write_byte;
    } in_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       need_data;
        logic       nack_seen;
        logic       busy_res;
        logic       done_res;
    } out_t;

endpackage

### design/i2c_master_register_transfer.sv
// Latency: a result is presented in the cycle after its input transfer is accepted.
// Throughput: one item per cycle unless m_ready stalls; the sequencer state advances in the
// accept cycle and the result register is refilled while its current result is being taken.
// Reset (aresetn low, synchronous): sequencer idle, lines released, wait registers at
// 10 and 30 ticks, result register empty.
module i2c_master_register_transfer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  i2cmrt_pkg::in_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output i2cmrt_pkg::out_t  m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_addr,
    input  logic [7:0]        cfg_data
);
    import i2cmrt_pkg::*;

    `include "i2c_master_register_transfer_assert.svh"

    localparam logic [4:0] PH_IDLE = 5'd0;
    localparam logic [4:0] PH_ST_A = 5'd1;
    localparam logic [4:0] PH_ST_B = 5'd2;
    localparam logic [4:0] PH_ST_C = 5'd3;
    localparam logic [4:0] PH_ST_D = 5'd4;
    localparam logic [4:0] PH_TX_D = 5'd5;
    localparam logic [4:0] PH_TX_H = 5'd6;
    localparam logic [4:0] PH_TX_L = 5'd7;
    localparam logic [4:0] PH_AK_R = 5'd8;
    localparam logic [4:0] PH_AK_H = 5'd9;
    localparam logic [4:0] PH_AK_S = 5'd10;
    localparam logic [4:0] PH_NEED = 5'd11;
    localparam logic [4:0] PH_WAIT = 5'd12;
    localparam logic [4:0] PH_RX_R = 5'd13;
    localparam logic [4:0] PH_RX_H = 5'd14;
    localparam logic [4:0] PH_RX_S = 5'd15;
    localparam logic [4:0] PH_MA_D = 5'd16;
    localparam logic [4:0] PH_MA_H = 5'd17;
    localparam logic [4:0] PH_MA_L = 5'd18;
    localparam logic [4:0] PH_SP_A = 5'd19;
    localparam logic [4:0] PH_SP_B = 5'd20;
    localparam logic [4:0] PH_SP_C = 5'd21;

    localparam logic [1:0] KIND_ADDR_W = 2'd0;
    localparam logic [1:0] KIND_REG    = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;
    localparam logic [1:0] KIND_ADDR_R = 2'd3;

    logic [7:0] restart_wait_reg;
    logic [7:0] stop_wait_reg;

    logic [4:0] phase_reg,      phase_next;
    logic [2:0] bit_index_reg,  bit_index_next;
    logic [7:0] shift_reg,      shift_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [6:0] addr_latch_reg, addr_latch_next;
    logic [7:0] reg_latch_reg,  reg_latch_next;
    logic       is_read_reg,    is_read_next;
    logic [7:0] wait_count_reg, wait_count_next;
    logic       nack_flag_reg,  nack_flag_next;
    logic       scl_reg,        scl_next;
    logic       sda_reg,        sda_next;
    logic [1:0] kind_reg,       kind_next;

    logic       m_valid_reg;
    out_t       m_data_reg;
    out_t       result;
    logic       accept;
    logic       rx_valid;
    logic [7:0] rx_out;
    logic       done;
    logic [7:0] wait_dec;
    logic [7:0] bytes_dec;
    logic [7:0] rx_shift;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign wait_dec  = wait_count_reg - 8'd1;
    assign bytes_dec = bytes_left_reg - 8'd1;
    assign rx_shift  = {shift_reg[6:0], s_data.sda_in};

    always_comb begin
        phase_next      = phase_reg;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        bytes_left_next = bytes_left_reg;
        addr_latch_next = addr_latch_reg;
        reg_latch_next  = reg_latch_reg;
        is_read_next    = is_read_reg;
        wait_count_next = wait_count_reg;
        nack_flag_next  = nack_flag_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        kind_next       = kind_reg;
        rx_valid        = 1'b0;
        rx_out          = 8'd0;
        done            = 1'b0;

        case (s_data.op) inside
            OP_WRITE, OP_READ: begin
                if (phase_reg == PH_IDLE) begin
                    addr_latch_next = s_data.device_addr;
                    reg_latch_next  = s_data.reg_addr;
                    bytes_left_next = (s_data.byte_count == 8'd0) ? 8'd1 : s_data.byte_count;
                    is_read_next    = (s_data.op == OP_READ);
                    nack_flag_next  = 1'b0;
                    kind_next       = KIND_ADDR_W;
                    bit_index_next  = 3'd0;
                    shift_next      = 8'd0;
                    wait_count_next = 8'd0;
                    phase_next      = PH_ST_A;
                end
            end
            OP_DATA: begin
                if (phase_reg == PH_NEED) begin
                    shift_next     = s_data.write_byte;
                    bit_index_next = 3'd0;
                    phase_next     = PH_TX_D;
                end
            end
            default: begin
                unique case (phase_reg)
                    PH_ST_A: begin sda_next = 1'b1; phase_next = PH_ST_B; end
                    PH_ST_B: begin scl_next = 1'b1; phase_next = PH_ST_C; end
                    PH_ST_C: begin sda_next = 1'b0; phase_next = PH_ST_D; end
                    PH_ST_D: begin
                        scl_next       = 1'b0;
                        shift_next     = {addr_latch_reg, kind_reg == KIND_ADDR_R};
                        bit_index_next = 3'd0;
                        phase_next     = PH_TX_D;
                    end
                    PH_TX_D: begin sda_next = shift_reg[7]; phase_next = PH_TX_H; end
                    PH_TX_H: begin scl_next = 1'b1; phase_next = PH_TX_L; end
                    PH_TX_L: begin
                        scl_next   = 1'b0;
                        shift_next = {shift_reg[6:0], 1'b0};
                        if (bit_index_reg == 3'd7) begin
                            phase_next = PH_AK_R;
                        end else begin
                            bit_index_next = bit_index_reg + 3'd1;
                            phase_next     = PH_TX_D;
                        end
                    end
                    PH_AK_R: begin sda_next = 1'b1; phase_next = PH_AK_H; end
                    PH_AK_H: begin scl_next = 1'b1; phase_next = PH_AK_S; end
                    PH_AK_S: begin
                        if (s_data.sda_in) begin
                            nack_flag_next = 1'b1;
                        end
                        scl_next = 1'b0;
                        unique case (kind_reg)
                            KIND_ADDR_W: begin
                                kind_next      = KIND_REG;
                                shift_next     = reg_latch_reg;
                                bit_index_next = 3'd0;
                                phase_next     = PH_TX_D;
                            end
                            KIND_REG: begin
                                if (!is_read_reg) begin
                                    kind_next  = KIND_DATA;
                                    phase_next = PH_NEED;
                                end else if (restart_wait_reg == 8'd0) begin
                                    kind_next  = KIND_ADDR_R;
                                    phase_next = PH_ST_A;
                                end else begin
                                    wait_count_next = restart_wait_reg;
                                    phase_next      = PH_WAIT;
                                end
                            end
                            KIND_DATA: begin
                                bytes_left_next = bytes_dec;
                                if (bytes_dec != 8'd0) begin
                                    phase_next = PH_NEED;
                                end else if (stop_wait_reg == 8'd0) begin
                                    phase_next = PH_SP_A;
                                end else begin
                                    wait_count_next = stop_wait_reg;
                                    phase_next      = PH_WAIT;
                                end
                            end
                            default: begin
                                shift_next     = 8'd0;
                                bit_index_next = 3'd0;
                                phase_next     = PH_RX_R;
                            end
                        endcase
                    end
                    PH_WAIT: begin
                        wait_count_next = wait_dec;
                        if (wait_dec == 8'd0) begin
                            // The wait after the register byte leads into the repeated start.
                            if (kind_reg == KIND_REG) begin
                                kind_next  = KIND_ADDR_R;
                                phase_next = PH_ST_A;
                            end else begin
                                phase_next = PH_SP_A;
                            end
                        end
                    end
                    PH_RX_R: begin sda_next = 1'b1; phase_next = PH_RX_H; end
                    PH_RX_H: begin scl_next = 1'b1; phase_next = PH_RX_S; end
                    PH_RX_S: begin
                        shift_next = rx_shift;
                        scl_next   = 1'b0;
                        if (bit_index_reg == 3'd7) begin
                            rx_valid        = 1'b1;
                            rx_out          = rx_shift;
                            bytes_left_next = bytes_dec;
                            phase_next      = PH_MA_D;
                        end else begin
                            bit_index_next = bit_index_reg + 3'd1;
                            phase_next     = PH_RX_H;
                        end
                    end
                    PH_MA_D: begin
                        // The last byte is answered with a NACK.
                        sda_next   = (bytes_left_reg == 8'd0);
                        phase_next = PH_MA_H;
                    end
                    PH_MA_H: begin scl_next = 1'b1; phase_next = PH_MA_L; end
                    PH_MA_L: begin
                        scl_next = 1'b0;
                        if (bytes_left_reg != 8'd0) begin
                            shift_next     = 8'd0;
                            bit_index_next = 3'd0;
                            phase_next     = PH_RX_R;
                        end else if (stop_wait_reg == 8'd0) begin
                            phase_next = PH_SP_A;
                        end else begin
                            wait_count_next = stop_wait_reg;
                            phase_next      = PH_WAIT;
                        end
                    end
                    PH_SP_A: begin sda_next = 1'b0; phase_next = PH_SP_B; end
                    PH_SP_B: begin scl_next = 1'b1; phase_next = PH_SP_C; end
                    PH_SP_C: begin
                        sda_next   = 1'b1;
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
        endcase

        result.scl       = scl_next;
        result.sda       = sda_next;
        result.rx_byte   = rx_out;
        result.rx_valid  = rx_valid;
        result.need_data = (phase_next == PH_NEED);
        result.nack_seen = nack_flag_next;
        result.busy_res  = (phase_next != PH_IDLE);
        result.done_res  = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            restart_wait_reg <= RESTART_WAIT_RESET;
            stop_wait_reg    <= STOP_WAIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                CFG_RESTART_WAIT: restart_wait_reg <= cfg_data;
                CFG_STOP_WAIT:    stop_wait_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bit_index_reg  <= 3'd0;
            shift_reg      <= 8'd0;
            bytes_left_reg <= 8'd0;
            addr_latch_reg <= 7'd0;
            reg_latch_reg  <= 8'd0;
            is_read_reg    <= 1'b0;
            wait_count_reg <= 8'd0;
            nack_flag_reg  <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            kind_reg       <= KIND_ADDR_W;
        end else if (accept) begin
            phase_reg      <= phase_next;
            bit_index_reg  <= bit_index_next;
            shift_reg      <= shift_next;
            bytes_left_reg <= bytes_left_next;
            addr_latch_reg <= addr_latch_next;
            reg_latch_reg  <= reg_latch_next;
            is_read_reg    <= is_read_next;
            wait_count_reg <= wait_count_next;
            nack_flag_reg  <= nack_flag_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            kind_reg       <= kind_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

    `I2CMRT_ASSERT(a_accept_fills_result, (s_valid && s_ready) |=> m_valid)
    `I2CMRT_ASSERT(a_need_while_busy, (m_valid && m_data.need_data) |-> m_data.busy_res)
    `I2CMRT_ASSERT(a_done_releases, (m_valid && m_data.done_res) |-> (!m_data.busy_res && m_data.scl && m_data.sda))
    `I2CMRT_ASSERT(a_rx_only_in_read, (m_valid && m_data.rx_valid) |-> is_read_reg)
    `I2CMRT_ASSERT_ALWAYS(a_cfg_always_ready, cfg_ready)

endmodule
